// ----- rtl/tps_pkg.sv -----
package tps_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned NormW       = 32;
  localparam int unsigned OffW        = 26;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CrossW      = 35;
  localparam int unsigned MagW        = 34;
  localparam int unsigned ShW         = 31;
  localparam int unsigned SumW        = 64;
  localparam int unsigned LenW        = 32;
  localparam int unsigned DivNumW     = 62;
  localparam int unsigned QW          = 31;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 31;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vtx_t;

  // Lexicographic compare on (x, y, z).
  function automatic logic vtx_gt(input vtx_t p, input vtx_t q);
    logic r;
    begin
      if (p.x != q.x) r = (p.x > q.x);
      else if (p.y != q.y) r = (p.y > q.y);
      else r = (p.z > q.z);
      return r;
    end
  endfunction

endpackage

// ----- rtl/tps_sqrt_stage.sv -----
// One restoring square-root step: two radicand bits per stage.
module tps_sqrt_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic [tps_pkg::SumW-1:0] rem_i,
  input  logic [tps_pkg::LenW-1:0] root_i,
  input  logic [tps_pkg::SumW-1:0] s_i,
  output logic [tps_pkg::SumW-1:0] rem_o,
  output logic [tps_pkg::LenW-1:0] root_o
);
  localparam int unsigned Pos = tps_pkg::SumW - 2 - 2 * STEP;
  logic [tps_pkg::SumW+1:0] rem_sh;
  logic [tps_pkg::SumW+1:0] trial;

  always_comb begin
    rem_sh = {rem_i, s_i[Pos +: 2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_o  = tps_pkg::SumW'(rem_sh - trial);
      root_o = {root_i[tps_pkg::LenW-2:0], 1'b1};
    end else begin
      rem_o  = tps_pkg::SumW'(rem_sh);
      root_o = {root_i[tps_pkg::LenW-2:0], 1'b0};
    end
  end
endmodule

// ----- rtl/triangle_plane_setup_top.sv -----
// Triangle plane setup: sort, cross product, normalize, offset.
// 74 register stages lie between the edge taking start and out_valid.
// Stages: 8 front, 32 square-root, 31 divider, 2 offset, 1 output register.
// Throughput: one triangle per clock; busy is tied low, every cycle may start.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// The receiver cannot stall: out_valid pulses one cycle per item.
module triangle_plane_setup_top #(
  parameter int unsigned COORD_FRAC_BITS = tps_pkg::FracBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] in_ax,
  input  logic signed [15:0] in_ay,
  input  logic signed [15:0] in_az,
  input  logic signed [15:0] in_bx,
  input  logic signed [15:0] in_by_coord,
  input  logic signed [15:0] in_bz,
  input  logic signed [15:0] in_cx,
  input  logic signed [15:0] in_cy,
  input  logic signed [15:0] in_cz,
  output logic out_valid,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z,
  output logic signed [25:0] out_plane_offset,
  output logic out_degenerate
);
  localparam int unsigned SQ = tps_pkg::SqrtSteps;
  localparam int unsigned DV = tps_pkg::DivSteps;
  localparam int unsigned RndSh = 14 + COORD_FRAC_BITS;
  localparam int unsigned DotW = 52;

  assign busy = 1'b0;

  // ---- stage 1: sort network, hold parity
  tps_pkg::vtx_t a0, b0, c0, a1, b1, c1, a2, b2, c2, a3, b3;
  logic p1, p2, p3;
  always_comb begin
    a0 = '{in_ax, in_ay, in_az};
    b0 = '{in_bx, in_by_coord, in_bz};
    c0 = '{in_cx, in_cy, in_cz};
    p1 = tps_pkg::vtx_gt(a0, b0);
    a1 = p1 ? b0 : a0;  b1 = p1 ? a0 : b0;  c1 = c0;
    p2 = tps_pkg::vtx_gt(b1, c1);
    a2 = a1;  b2 = p2 ? c1 : b1;  c2 = p2 ? b1 : c1;
    p3 = tps_pkg::vtx_gt(a2, b2);
    a3 = p3 ? b2 : a2;  b3 = p3 ? a2 : b2;
  end

  logic v1_r;
  tps_pkg::vtx_t a_s1_r, b_s1_r, c_s1_r;
  logic odd_s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    a_s1_r <= a3;  b_s1_r <= b3;  c_s1_r <= c2;
    odd_s1_r <= p1 ^ p2 ^ p3;
  end

  // ---- stage 2: edge vectors
  logic signed [16:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic v2_r, odd_s2_r;
  tps_pkg::vtx_t a_s2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    ux_r <= 17'(b_s1_r.x) - 17'(a_s1_r.x);
    uy_r <= 17'(b_s1_r.y) - 17'(a_s1_r.y);
    uz_r <= 17'(b_s1_r.z) - 17'(a_s1_r.z);
    vx_r <= 17'(c_s1_r.x) - 17'(a_s1_r.x);
    vy_r <= 17'(c_s1_r.y) - 17'(a_s1_r.y);
    vz_r <= 17'(c_s1_r.z) - 17'(a_s1_r.z);
    odd_s2_r <= odd_s1_r;  a_s2_r <= a_s1_r;
  end

  // ---- stage 3: six products
  logic signed [33:0] pr_r [6];
  logic v3_r, odd_s3_r;
  tps_pkg::vtx_t a_s3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    pr_r[0] <= uy_r * vz_r;  pr_r[1] <= uz_r * vy_r;
    pr_r[2] <= uz_r * vx_r;  pr_r[3] <= ux_r * vz_r;
    pr_r[4] <= ux_r * vy_r;  pr_r[5] <= uy_r * vx_r;
    odd_s3_r <= odd_s2_r;  a_s3_r <= a_s2_r;
  end

  // ---- stage 4: cross product, sign and magnitude
  logic signed [34:0] cr [3];
  logic [33:0] mg4_r [3];
  logic [2:0] neg4_r;
  logic v4_r, odd_s4_r;
  tps_pkg::vtx_t a_s4_r;
  always_comb begin
    cr[0] = 35'(pr_r[0]) - 35'(pr_r[1]);
    cr[1] = 35'(pr_r[2]) - 35'(pr_r[3]);
    cr[2] = 35'(pr_r[4]) - 35'(pr_r[5]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    for (int i = 0; i < 3; i++) begin
      neg4_r[i] <= cr[i][34];
      mg4_r[i]  <= cr[i][34] ? 34'(-cr[i]) : 34'(cr[i]);
    end
    odd_s4_r <= odd_s3_r;  a_s4_r <= a_s3_r;
  end

  // ---- stage 5: bit length of the largest magnitude, from the OR of all three
  logic [33:0] mx;
  logic [5:0] bl;
  logic [5:0] bl5_r;
  logic [33:0] mg5_r [3];
  logic [2:0] neg5_r;
  logic v5_r, odd_s5_r;
  tps_pkg::vtx_t a_s5_r;
  always_comb begin
    mx = mg4_r[0] | mg4_r[1] | mg4_r[2];
    bl = '0;
    for (int i = 0; i < 34; i++) if (mx[i]) bl = 6'(i + 1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    bl5_r <= bl;  mg5_r <= mg4_r;  neg5_r <= neg4_r;
    odd_s5_r <= odd_s4_r;  a_s5_r <= a_s4_r;
  end

  // ---- stage 6: shift so the max has 31 significant bits
  logic [30:0] sh6_r [3];
  logic [2:0] neg6_r;
  logic deg6_r, v6_r, odd_s6_r;
  tps_pkg::vtx_t a_s6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    for (int i = 0; i < 3; i++) begin
      if (bl5_r > 6'd31) sh6_r[i] <= 31'(mg5_r[i] >> (bl5_r - 6'd31));
      else sh6_r[i] <= 31'(mg5_r[i] << (6'd31 - bl5_r));
    end
    deg6_r <= (bl5_r == '0);
    neg6_r <= neg5_r;  odd_s6_r <= odd_s5_r;  a_s6_r <= a_s5_r;
  end

  // ---- stage 7: squares
  logic [61:0] sq7_r [3];
  logic [30:0] sh7_r [3];
  logic [2:0] neg7_r;
  logic deg7_r, v7_r, odd_s7_r;
  tps_pkg::vtx_t a_s7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
    for (int i = 0; i < 3; i++) sq7_r[i] <= sh6_r[i] * sh6_r[i];
    sh7_r <= sh6_r;  neg7_r <= neg6_r;  deg7_r <= deg6_r;
    odd_s7_r <= odd_s6_r;  a_s7_r <= a_s6_r;
  end

  // ---- stage 8: sum of squares
  logic [63:0] s8_r;
  logic [30:0] sh8_r [3];
  logic [2:0] neg8_r;
  logic deg8_r, v8_r, odd_s8_r;
  tps_pkg::vtx_t a_s8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else v8_r <= v7_r;
    s8_r <= 64'(sq7_r[0]) + 64'(sq7_r[1]) + 64'(sq7_r[2]);
    sh8_r <= sh7_r;  neg8_r <= neg7_r;  deg8_r <= deg7_r;
    odd_s8_r <= odd_s7_r;  a_s8_r <= a_s7_r;
  end

  // ---- square root: one result bit per stage
  logic [63:0] sq_s_r [SQ+1];
  logic [63:0] sq_rem_r [SQ+1];
  logic [31:0] sq_root_r [SQ+1];
  logic [30:0] sq_sh_r [SQ+1][3];
  logic [2:0] sq_neg_r [SQ+1];
  logic sq_deg_r [SQ+1];
  logic sq_v_r [SQ+1];
  logic sq_odd_r [SQ+1];
  tps_pkg::vtx_t sq_a_r [SQ+1];

  always_comb begin
    sq_s_r[0] = s8_r;  sq_rem_r[0] = '0;  sq_root_r[0] = '0;
    sq_sh_r[0] = sh8_r;  sq_neg_r[0] = neg8_r;  sq_deg_r[0] = deg8_r;
    sq_v_r[0] = v8_r;  sq_odd_r[0] = odd_s8_r;  sq_a_r[0] = a_s8_r;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [63:0] rem_n;
    logic [31:0] root_n;
    tps_sqrt_stage #(.STEP(k)) u_stage (
      .rem_i(sq_rem_r[k]), .root_i(sq_root_r[k]), .s_i(sq_s_r[k]),
      .rem_o(rem_n), .root_o(root_n)
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else sq_v_r[k+1] <= sq_v_r[k];
      sq_rem_r[k+1] <= rem_n;  sq_root_r[k+1] <= root_n;
      sq_s_r[k+1] <= sq_s_r[k];  sq_sh_r[k+1] <= sq_sh_r[k];
      sq_neg_r[k+1] <= sq_neg_r[k];  sq_deg_r[k+1] <= sq_deg_r[k];
      sq_odd_r[k+1] <= sq_odd_r[k];  sq_a_r[k+1] <= sq_a_r[k];
    end
  end

  // ---- divider: three lanes, one quotient bit per stage
  // numerator = sh << 30 + floor(L/2), 62 bits; quotient fits 31 bits.
  logic [31:0] len;
  assign len = (sq_root_r[SQ] == '0) ? 32'd1 : sq_root_r[SQ];

  logic [tps_pkg::DivNumW-1:0] dv_num_r [DV+1][3];
  logic [32:0] dv_rem_r [DV+1][3];
  logic [30:0] dv_q_r [DV+1][3];
  logic [31:0] dv_len_r [DV+1];
  logic [2:0] dv_neg_r [DV+1];
  logic dv_deg_r [DV+1];
  logic dv_v_r [DV+1];
  logic dv_odd_r [DV+1];
  tps_pkg::vtx_t dv_a_r [DV+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num_r[0][i] = tps_pkg::DivNumW'({sq_sh_r[SQ][i], 30'd0}) +
                       tps_pkg::DivNumW'(len[31:1]);
      dv_rem_r[0][i] = '0;
      dv_q_r[0][i]   = '0;
    end
    dv_len_r[0] = len;  dv_neg_r[0] = sq_neg_r[SQ];  dv_deg_r[0] = sq_deg_r[SQ];
    dv_v_r[0] = sq_v_r[SQ];  dv_odd_r[0] = sq_odd_r[SQ];  dv_a_r[0] = sq_a_r[SQ];
  end

  // Quotient bits 30..0; the top numerator bits load the remainder first.
  for (genvar k = 0; k < DV; k++) begin : g_div
    localparam int unsigned Bit = DV - 1 - k;
    logic [32:0] rem_n [3];
    logic [30:0] q_n [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        logic [33:0] t;
        if (k == 0) t = 34'(dv_num_r[k][i] >> (Bit));
        else t = {dv_rem_r[k][i], dv_num_r[k][i][Bit]};
        q_n[i] = dv_q_r[k][i];
        if (t >= 34'(dv_len_r[k])) begin
          rem_n[i] = 33'(t - 34'(dv_len_r[k]));
          q_n[i][Bit] = 1'b1;
        end else begin
          rem_n[i] = 33'(t);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else dv_v_r[k+1] <= dv_v_r[k];
      dv_rem_r[k+1] <= rem_n;  dv_q_r[k+1] <= q_n;
      dv_num_r[k+1] <= dv_num_r[k];  dv_len_r[k+1] <= dv_len_r[k];
      dv_neg_r[k+1] <= dv_neg_r[k];  dv_deg_r[k+1] <= dv_deg_r[k];
      dv_odd_r[k+1] <= dv_odd_r[k];  dv_a_r[k+1] <= dv_a_r[k];
    end
  end

  // ---- signed normal, then n.A products
  logic signed [31:0] nrm [3];
  always_comb
    for (int i = 0; i < 3; i++)
      nrm[i] = dv_neg_r[DV][i] ? -32'(dv_q_r[DV][i]) : 32'(dv_q_r[DV][i]);

  logic signed [47:0] dp_r [3];
  logic signed [31:0] n9_r [3];
  logic deg9_r, v9_r, odd9_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else v9_r <= dv_v_r[DV];
    dp_r[0] <= nrm[0] * dv_a_r[DV].x;
    dp_r[1] <= nrm[1] * dv_a_r[DV].y;
    dp_r[2] <= nrm[2] * dv_a_r[DV].z;
    n9_r <= nrm;  deg9_r <= dv_deg_r[DV];  odd9_r <= dv_odd_r[DV];
  end

  // ---- dot sum and magnitude
  logic signed [DotW-1:0] dot;
  logic [DotW-1:0] dmag10_r;
  logic dneg10_r;
  logic signed [31:0] n10_r [3];
  logic deg10_r, v10_r, odd10_r;
  assign dot = DotW'(dp_r[0]) + DotW'(dp_r[1]) + DotW'(dp_r[2]);
  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else v10_r <= v9_r;
    dneg10_r <= dot[DotW-1];
    dmag10_r <= dot[DotW-1] ? DotW'(-dot) : DotW'(dot);
    n10_r <= n9_r;  deg10_r <= deg9_r;  odd10_r <= odd9_r;
  end

  // ---- round, saturate, apply parity and degenerate; drive outputs
  logic [DotW:0] rnd;
  logic [DotW:0] amag;
  logic [25:0] amag_sat;
  logic signed [25:0] off;
  always_comb begin
    rnd  = (DotW+1)'(dmag10_r) + ((DotW+1)'(1) << (RndSh - 1));
    amag = rnd >> RndSh;
    amag_sat = (amag > (DotW+1)'(16777216)) ? 26'd16777216 : 26'(amag);
    off = dneg10_r ? $signed(amag_sat) : -$signed(amag_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v10_r;
    out_degenerate <= deg10_r;
    if (deg10_r) begin
      out_normal_x <= '0;  out_normal_y <= '0;  out_normal_z <= '0;
      out_plane_offset <= '0;
    end else if (odd10_r) begin
      out_normal_x <= -n10_r[0];  out_normal_y <= -n10_r[1];
      out_normal_z <= -n10_r[2];  out_plane_offset <= -off;
    end else begin
      out_normal_x <= n10_r[0];  out_normal_y <= n10_r[1];
      out_normal_z <= n10_r[2];  out_plane_offset <= off;
    end
  end
endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One plane equation as the block reports it.
  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic signed [25:0] offset;
    logic               degen;
  } plane_t;

  // Predicts plane equations and matches them against the block's results in order.
  class plane_board;
    plane_t pending[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // Lexicographic "p above q" on (x, y, z).
    static function bit above(longint px, longint py, longint pz,
                              longint qx, longint qy, longint qz);
      bit r;
      if (px != qx) r = px > qx;
      else if (py != qy) r = py > qy;
      else r = pz > qz;
      return r;
    endfunction

    static function longint unsigned root_floor(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Work out the plane for one triangle and queue it.
    function void note_triangle(logic signed [15:0] v[9]);
      longint p[3][3], t, cr[3], nrm[3], dotp, off;
      longint unsigned mg[3], m, s, len, q, acc;
      int bl, i, k;
      bit odd;
      plane_t e;
      for (i = 0; i < 3; i++)
        for (k = 0; k < 3; k++) p[i][k] = longint'(v[3*i+k]);
      odd = 1'b0;
      // Exchange network: A:B, B:C, A:B.
      foreach (cr[j]) begin
        int lo;
        lo = (j == 1) ? 1 : 0;
        if (above(p[lo][0], p[lo][1], p[lo][2], p[lo+1][0], p[lo+1][1], p[lo+1][2])) begin
          for (k = 0; k < 3; k++) begin
            t = p[lo][k]; p[lo][k] = p[lo+1][k]; p[lo+1][k] = t;
          end
          odd = !odd;
        end
      end
      begin
        longint ux, uy, uz, wx, wy, wz;
        ux = p[1][0]-p[0][0]; uy = p[1][1]-p[0][1]; uz = p[1][2]-p[0][2];
        wx = p[2][0]-p[0][0]; wy = p[2][1]-p[0][1]; wz = p[2][2]-p[0][2];
        cr[0] = uy*wz - uz*wy;
        cr[1] = uz*wx - ux*wz;
        cr[2] = ux*wy - uy*wx;
      end
      if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
        e.nx = '0; e.ny = '0; e.nz = '0; e.offset = '0; e.degen = 1'b1;
        pending.push_back(e);
        return;
      end
      m = 0;
      for (i = 0; i < 3; i++) begin
        mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
        if (mg[i] > m) m = mg[i];
      end
      bl = 0;
      while (bl < 64 && (m >> bl) != 0) bl++;
      for (i = 0; i < 3; i++)
        if (bl > 31) mg[i] >>= (bl - 31);
        else mg[i] <<= (31 - bl);
      s = mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2];
      len = root_floor(s);
      if (len == 0) len = 1;
      for (i = 0; i < 3; i++) begin
        q = ((mg[i] << 30) + (len >> 1)) / len;
        nrm[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
      end
      dotp = nrm[0]*p[0][0] + nrm[1]*p[0][1] + nrm[2]*p[0][2];
      acc = dotp < 0 ? -dotp : dotp;
      acc = (acc + (64'd1 << (13 + tps_pkg::FracBitsDef))) >> (14 + tps_pkg::FracBitsDef);
      if (acc > 16777216) acc = 16777216;
      off = dotp < 0 ? longint'(acc) : -longint'(acc);
      if (odd) begin
        for (i = 0; i < 3; i++) nrm[i] = -nrm[i];
        off = -off;
      end
      e.nx = 32'(nrm[0]); e.ny = 32'(nrm[1]); e.nz = 32'(nrm[2]);
      e.offset = 26'(off); e.degen = 1'b0;
      pending.push_back(e);
    endfunction

    function void check_plane(plane_t got);
      plane_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: no plane pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx) begin
        $error("normal_x: expected %0d actual %0d", e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y: expected %0d actual %0d", e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $error("normal_z: expected %0d actual %0d", e.nz, got.nz); errors++;
      end
      if (got.offset !== e.offset) begin
        $error("plane_offset: expected %0d actual %0d", e.offset, got.offset); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate: expected %0d actual %0d", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] in_ax = 0, in_ay = 0, in_az = 0, in_bx = 0, in_by_coord = 0;
  logic signed [15:0] in_bz = 0, in_cx = 0, in_cy = 0, in_cz = 0;
  logic out_valid;
  logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [25:0] out_plane_offset;
  logic out_degenerate;

  plane_board board = new();
  bit calm = 0;  // no idle bursts in the last stretch

  triangle_plane_setup_top dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Check every result on the edge that ends its strobe cycle.
  always @(posedge clk) begin
    plane_t got;
    if (rst_n && out_valid) begin
      got.nx = out_normal_x; got.ny = out_normal_y; got.nz = out_normal_z;
      got.offset = out_plane_offset; got.degen = out_degenerate;
      board.check_plane(got);
    end
  end

  // Present one triangle; hold start until an edge accepts it with busy low.
  task automatic send_triangle(logic signed [15:0] v[9]);
    start <= 1;
    in_ax <= v[0]; in_ay <= v[1]; in_az <= v[2];
    in_bx <= v[3]; in_by_coord <= v[4]; in_bz <= v[5];
    in_cx <= v[6]; in_cy <= v[7]; in_cz <= v[8];
    do @(posedge clk); while (busy);
    board.note_triangle(v);
    @(negedge clk);
  endtask

  // Drop start and idle for a random burst now and then.
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    logic signed [15:0] r;
    case ($urandom_range(0, 5))
      0: r = 16'sh7fff;
      1: r = 16'sh8000;
      2: r = 16'(int'($urandom_range(0, 64)) - 32);
      default: r = 16'($urandom);
    endcase
    return r;
  endfunction

  initial begin
    logic signed [15:0] v[9];
    logic signed [15:0] ext[4];
    int n, i, sel;
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: degenerate (all equal, collinear), extremes, sort orders.
    v = '{default: 0};
    send_triangle(v);
    v = '{16'sh0100, 0, 0, 16'sh0200, 0, 0, 16'sh0300, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0};
    send_triangle(v);
    v = '{16'sh0100, 0, 0, 0, 0, 0, 0, 16'sh0100, 0};
    send_triangle(v);
    v = '{0, 16'sh0100, 0, 16'sh0100, 0, 0, 0, 0, 0};
    send_triangle(v);
    v = '{0, 0, 16'sh0100, 0, 0, 0, 0, 16'sh0100, 0};
    send_triangle(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh8000};
    send_triangle(v);
    v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh8000};
    send_triangle(v);
    // Equal vertices except one: no swap among the pair.
    v = '{16'sh0010, 16'sh0020, 16'sh0030, 16'sh0010, 16'sh0020, 16'sh0030,
          16'sh0040, 16'sh0050, 16'sh0060};
    send_triangle(v);
    for (n = 0; n < 12; n++) begin
      for (i = 0; i < 9; i++) v[i] = ext[$urandom_range(0, 3)];
      send_triangle(v);
    end

    // Hold off until every plane has come back.
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);

    for (n = 0; n < 850; n++) begin
      if (n == 700) calm = 1;
      case ($urandom_range(0, 9))
        0: begin  // collinear: C = A + k(B - A)
          for (i = 0; i < 6; i++) v[i] = 16'(int'($urandom_range(0, 2000)) - 1000);
          for (i = 0; i < 3; i++) v[6+i] = 16'(v[i] + 16'sd2 * (v[3+i] - v[i]));
        end
        1: begin  // shared vertices
          for (i = 0; i < 9; i++) v[i] = rand_coord();
          sel = int'($urandom_range(0, 2));
          for (i = 0; i < 3; i++) v[3*sel+i] = v[i];
        end
        2: for (i = 0; i < 9; i++) v[i] = 16'(int'($urandom_range(0, 6)) - 3);
        default: for (i = 0; i < 9; i++) v[i] = rand_coord();
      endcase
      send_triangle(v);
      maybe_idle();
    end
    start <= 0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("triangle_plane_setup_top regression: pass");
    else
      $display("triangle_plane_setup_top regression: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("triangle_plane_setup_top regression: fail");
    $finish;
  end
endmodule
